// File: hw/rtl/sbas_pkg.sv
// ----------------------------------------------------------------------------
// sbas_pkg
// Shared widths, field positions, types and modes of the signed BCD
// add / subtract pipeline.
// ----------------------------------------------------------------------------
package sbas_pkg;

   localparam int MAX_DIGITS = 16;
   localparam int DIGITS_DEF = 16;
   localparam int DIGIT_W    = 4;
   localparam int WORD_W     = MAX_DIGITS * DIGIT_W;

   // request beat: a_digits, a_negative, b_digits, b_negative, zero fill
   localparam int A_LO       = 0;
   localparam int A_NEG_BIT  = A_LO + WORD_W;
   localparam int B_LO       = A_NEG_BIT + 1;
   localparam int B_NEG_BIT  = B_LO + WORD_W;
   localparam int REQ_USED_W = B_NEG_BIT + 1;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // response beat: result_digits, result_negative, overflow, zero fill
   localparam int RES_NEG_BIT = WORD_W;
   localparam int OVF_BIT     = RES_NEG_BIT + 1;
   localparam int RSP_USED_W  = OVF_BIT + 1;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [DIGIT_W:0] BCD_BASE = 5'd10;
   localparam logic [DIGIT_W:0] BCD_NINE = 5'd9;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_SUB_AB = 2'd1,
      MODE_SUB_BA = 2'd2
   } mode_type;

   typedef struct packed {
      logic add_gen;
      logic add_prop;
      logic ab_gen;
      logic ba_gen;
      logic eq;
   } lane_flags_type;

endpackage

// File: hw/rtl/sbas_lane.sv
// ----------------------------------------------------------------------------
// sbas_lane
// One digit lane: folds each nibble into 0..9 and works out the carry and
// borrow generate / propagate flags of this digit.
// ----------------------------------------------------------------------------
module sbas_lane (
   input  logic [sbas_pkg::DIGIT_W-1:0] a_nib,
   input  logic [sbas_pkg::DIGIT_W-1:0] b_nib,
   output logic [sbas_pkg::DIGIT_W-1:0] a_dig,
   output logic [sbas_pkg::DIGIT_W-1:0] b_dig,
   output sbas_pkg::lane_flags_type     flags
);
   import sbas_pkg::*;

   logic [DIGIT_W:0] sum;

   // nibbles 10..15 read as 0..5
   always_comb begin
      a_dig = ({1'b0, a_nib} >= BCD_BASE) ? a_nib - BCD_BASE[DIGIT_W-1:0] : a_nib;
      b_dig = ({1'b0, b_nib} >= BCD_BASE) ? b_nib - BCD_BASE[DIGIT_W-1:0] : b_nib;
   end

   assign sum = {1'b0, a_dig} + {1'b0, b_dig};

   always_comb begin
      flags.add_gen  = (sum >= BCD_BASE);
      flags.add_prop = (sum == BCD_NINE);
      flags.ab_gen   = (a_dig < b_dig);
      flags.ba_gen   = (b_dig < a_dig);
      flags.eq       = (a_dig == b_dig);
   end

endmodule

// File: hw/rtl/sbas_carry.sv
// ----------------------------------------------------------------------------
// sbas_carry
// Parallel prefix over the lane flags: group generate of digits 0..i for
// every i, giving each lane its decimal carry or borrow in log2 levels.
// ----------------------------------------------------------------------------
module sbas_carry #(
   parameter int DIGITS = sbas_pkg::DIGITS_DEF
) (
   input  logic [DIGITS-1:0] gen,
   input  logic [DIGITS-1:0] prop,
   output logic [DIGITS-1:0] grp
);
   import sbas_pkg::*;

   localparam int LEVELS = $clog2(DIGITS);

   logic [DIGITS-1:0] g_lv [0:LEVELS];
   logic [DIGITS-1:0] p_lv [0:LEVELS];

   assign g_lv[0] = gen;
   assign p_lv[0] = prop;

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar i = 0; i < DIGITS; i++) begin : g_node
         if (i >= (1 << l)) begin : g_join
            assign g_lv[l+1][i] = g_lv[l][i] | (p_lv[l][i] & g_lv[l][i-(1<<l)]);
            assign p_lv[l+1][i] = p_lv[l][i] & p_lv[l][i-(1<<l)];
         end else begin : g_pass
            assign g_lv[l+1][i] = g_lv[l][i];
            assign p_lv[l+1][i] = p_lv[l][i];
         end
      end
   end

   assign grp = g_lv[LEVELS];

endmodule

// File: hw/rtl/sbas_digit.sv
// ----------------------------------------------------------------------------
// sbas_digit
// One result digit: decimal add with carry in, or decimal subtract with
// borrow in in either direction.
// ----------------------------------------------------------------------------
module sbas_digit (
   input  logic [sbas_pkg::DIGIT_W-1:0] a_dig,
   input  logic [sbas_pkg::DIGIT_W-1:0] b_dig,
   input  logic                         carry_in,
   input  sbas_pkg::mode_type           mode,
   output logic [sbas_pkg::DIGIT_W-1:0] r_dig
);
   import sbas_pkg::*;

   logic [DIGIT_W:0] sum;
   logic [DIGIT_W:0] diff;
   logic [DIGIT_W:0] sum_fix;
   logic [DIGIT_W:0] diff_fix;
   logic [DIGIT_W-1:0] big;
   logic [DIGIT_W-1:0] little;

   always_comb begin
      big    = (mode == MODE_SUB_BA) ? b_dig : a_dig;
      little = (mode == MODE_SUB_BA) ? a_dig : b_dig;
      sum    = {1'b0, a_dig} + {1'b0, b_dig} + {{DIGIT_W{1'b0}}, carry_in};
      diff   = {1'b0, big} - {1'b0, little} - {{DIGIT_W{1'b0}}, carry_in};
      sum_fix  = (sum >= BCD_BASE) ? sum - BCD_BASE : sum;
      // a negative difference wraps, so adding ten brings it back to 0..9
      diff_fix = diff[DIGIT_W] ? diff + BCD_BASE : diff;
      case (mode)
         MODE_ADD:    r_dig = sum_fix[DIGIT_W-1:0];
         MODE_SUB_AB,
         MODE_SUB_BA: r_dig = diff_fix[DIGIT_W-1:0];
         default:     r_dig = '0;
      endcase
   end

endmodule

// File: hw/rtl/signed_bcd_add_subtract.sv
// Throughput: one beat per cycle while the response side does not stall; the
// prefix carry tree over the digit lanes sits between two register stages,
// so the rate does not depend on the data.
// Each stage holds when the stage after it is full and stalled.
// Reset clears the stage valid flags only; data registers are not reset.
// ----------------------------------------------------------------------------
// signed_bcd_add_subtract
// Sign-magnitude BCD add / subtract: digit lanes, prefix carry merge and
// result digit lanes in a three-stage pipeline.
// ----------------------------------------------------------------------------
module signed_bcd_add_subtract #(
   parameter int DIGITS = sbas_pkg::DIGITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // a_digits, a_negative, b_digits, b_negative, zero fill
   input  logic [sbas_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_digits, result_negative, overflow, zero fill
   output logic [sbas_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sbas_pkg::*;

   // ---------------- handshake ----------------
   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign rdy3 = !rsp_valid_ff || rsp_tready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req_tready = rdy1;

   assign s1_valid_in  = rdy1 ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in  = rdy2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = rdy3 ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- stage 1: digit lanes ----------------
   logic [DIGIT_W-1:0] a_dig_in [DIGITS];
   logic [DIGIT_W-1:0] b_dig_in [DIGITS];
   lane_flags_type     flags_in [DIGITS];
   logic [DIGIT_W-1:0] s1_a_ff  [DIGITS];
   logic [DIGIT_W-1:0] s1_b_ff  [DIGITS];
   lane_flags_type     s1_flags_ff [DIGITS];
   logic               s1_a_neg_ff;
   logic               s1_b_neg_ff;

   for (genvar i = 0; i < DIGITS; i++) begin : g_lane
      sbas_lane u_lane (
         .a_nib (req_tdata[A_LO + DIGIT_W*i +: DIGIT_W]),
         .b_nib (req_tdata[B_LO + DIGIT_W*i +: DIGIT_W]),
         .a_dig (a_dig_in[i]),
         .b_dig (b_dig_in[i]),
         .flags (flags_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_a_ff     <= a_dig_in;
         s1_b_ff     <= b_dig_in;
         s1_flags_ff <= flags_in;
         s1_a_neg_ff <= req_tdata[A_NEG_BIT];
         // subtraction flips the sign of b
         s1_b_neg_ff <= req_tdata[B_NEG_BIT] ^ req_tuser[0];
      end
   end

   // ---------------- stage 2: carry merge ----------------
   logic [DIGITS-1:0] add_gen, add_prop, ab_gen, ba_gen, eq_vec;
   logic [DIGITS-1:0] add_grp, ab_grp, ba_grp;
   logic [DIGITS-1:0] add_cin, ab_cin, ba_cin;

   for (genvar i = 0; i < DIGITS; i++) begin : g_flag
      assign add_gen[i]  = s1_flags_ff[i].add_gen;
      assign add_prop[i] = s1_flags_ff[i].add_prop;
      assign ab_gen[i]   = s1_flags_ff[i].ab_gen;
      assign ba_gen[i]   = s1_flags_ff[i].ba_gen;
      assign eq_vec[i]   = s1_flags_ff[i].eq;
      if (i == 0) begin : g_first
         assign add_cin[i] = 1'b0;
         assign ab_cin[i]  = 1'b0;
         assign ba_cin[i]  = 1'b0;
      end else begin : g_rest
         assign add_cin[i] = add_grp[i-1];
         assign ab_cin[i]  = ab_grp[i-1];
         assign ba_cin[i]  = ba_grp[i-1];
      end
   end

   sbas_carry #(.DIGITS(DIGITS)) u_carry_add (
      .gen (add_gen), .prop (add_prop), .grp (add_grp)
   );
   sbas_carry #(.DIGITS(DIGITS)) u_carry_ab (
      .gen (ab_gen), .prop (eq_vec), .grp (ab_grp)
   );
   sbas_carry #(.DIGITS(DIGITS)) u_carry_ba (
      .gen (ba_gen), .prop (eq_vec), .grp (ba_grp)
   );

   mode_type          s2_mode_in, s2_mode_ff;
   logic [DIGITS-1:0] s2_cin_in, s2_cin_ff;
   logic              s2_neg_in, s2_neg_ff;
   logic              s2_ovf_in, s2_ovf_ff;
   logic [DIGIT_W-1:0] s2_a_ff [DIGITS];
   logic [DIGIT_W-1:0] s2_b_ff [DIGITS];

   // a borrow out of a - b means |a| < |b|, so b keeps its sign
   always_comb begin
      if (s1_a_neg_ff == s1_b_neg_ff) begin
         s2_mode_in = MODE_ADD;
         s2_cin_in  = add_cin;
         s2_neg_in  = s1_a_neg_ff;
         s2_ovf_in  = add_grp[DIGITS-1];
      end else if (!ab_grp[DIGITS-1]) begin
         s2_mode_in = MODE_SUB_AB;
         s2_cin_in  = ab_cin;
         s2_neg_in  = s1_a_neg_ff;
         s2_ovf_in  = 1'b0;
      end else begin
         s2_mode_in = MODE_SUB_BA;
         s2_cin_in  = ba_cin;
         s2_neg_in  = s1_b_neg_ff;
         s2_ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_mode_ff <= s2_mode_in;
         s2_cin_ff  <= s2_cin_in;
         s2_neg_ff  <= s2_neg_in;
         s2_ovf_ff  <= s2_ovf_in;
      end
   end

   // ---------------- stage 3: result digits ----------------
   logic [DIGIT_W-1:0] r_dig [DIGITS];
   logic [WORD_W-1:0]  r_word;
   logic               r_zero;
   logic [RSP_DATA_W-1:0] rsp_data_in, rsp_data_ff;

   for (genvar i = 0; i < DIGITS; i++) begin : g_res
      sbas_digit u_digit (
         .a_dig    (s2_a_ff[i]),
         .b_dig    (s2_b_ff[i]),
         .carry_in (s2_cin_ff[i]),
         .mode     (s2_mode_ff),
         .r_dig    (r_dig[i])
      );
   end

   // digits above DIGITS read as zero
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_word
      if (i < DIGITS) begin : g_used
         assign r_word[DIGIT_W*i +: DIGIT_W] = r_dig[i];
      end else begin : g_unused
         assign r_word[DIGIT_W*i +: DIGIT_W] = '0;
      end
   end

   assign r_zero = ~|r_word;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[WORD_W-1:0]  = r_word;
      rsp_data_in[RES_NEG_BIT] = s2_neg_ff && !r_zero;
      rsp_data_in[OVF_BIT]     = s2_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid right after reset");

   a_zero_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[WORD_W-1:0] == '0) |-> !rsp_data_ff[RES_NEG_BIT])
      else $error("zero result marked negative");

   a_ovf_add_only: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_ovf_ff |-> (s2_mode_ff == MODE_ADD))
      else $error("overflow on a magnitude subtract");

   a_compare_once: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(ab_grp[DIGITS-1] && ba_grp[DIGITS-1]))
      else $error("both magnitudes compare smaller");

endmodule
